FILE: rtl/ppor_pkg.sv
// ppor_pkg: shared widths and pipeline context type for the particle pair overlap resolver
// used by every module under rtl; no dependencies
package ppor_pkg;

   localparam int AXES    = 3;
   localparam int IDX_W   = 16;
   localparam int COORD_W = 32;
   localparam int RAD_W   = 30;
   // radius sum, separation products and square root widths
   localparam int SUM_W   = RAD_W + 1;
   localparam int SQ_W    = 2 * SUM_W;
   localparam int NORM_W  = 2 * COORD_W;
   localparam int ROOT_W  = SQ_W / 2;
   localparam int QUO_W   = SUM_W;
   // one result bit per stage in the root and divide pipelines
   localparam int ROOT_STAGES = ROOT_W;
   localparam int DIV_STAGES  = QUO_W;

   // context that travels alongside the root and divide pipelines
   typedef struct packed {
      logic                              overlap;
      logic                              move_second;
      logic                              coincident;
      logic [AXES-1:0]                   d_neg;
      logic [IDX_W-1:0]                  moved_index;
      logic [AXES-1:0][COORD_W-1:0]      base;
      logic [SUM_W-1:0]                  rsum;
      logic [AXES-1:0][SQ_W-1:0]         prod;
   } ctx_type;

endpackage

FILE: rtl/ppor_front.sv
// ppor_front: four pipeline stages of separation, squares, sums and overlap decision
// depends on ppor_pkg
module ppor_front #(
   parameter int unsigned MAX_PARTICLES = 65536
) (
   input  logic                                               clock,
   input  logic                                               reset,
   input  logic                                               adv,
   input  logic                                               in_valid,
   input  logic [ppor_pkg::IDX_W-1:0]                         in_index_a,
   input  logic [ppor_pkg::IDX_W-1:0]                         in_index_b,
   input  logic [ppor_pkg::AXES-1:0][ppor_pkg::COORD_W-1:0]   in_pos_a,
   input  logic [ppor_pkg::AXES-1:0][ppor_pkg::COORD_W-1:0]   in_pos_b,
   input  logic [ppor_pkg::RAD_W-1:0]                         in_rad_a,
   input  logic [ppor_pkg::RAD_W-1:0]                         in_rad_b,
   output logic                                               out_valid,
   output ppor_pkg::ctx_type                                  out_ctx,
   output logic [ppor_pkg::SQ_W-1:0]                          out_rad
);

   localparam int AX = ppor_pkg::AXES;
   localparam int CW = ppor_pkg::COORD_W;
   localparam int SW = ppor_pkg::SUM_W;
   localparam int QW = ppor_pkg::SQ_W;
   localparam int NW = ppor_pkg::NORM_W;
   localparam int IW = ppor_pkg::IDX_W;
   localparam logic [24:0] MAX_P = 25'(MAX_PARTICLES);

   // stage 1 registers
   logic                    v1_ff;
   logic                    reject1_ff, reject1_in;
   logic [AX-1:0][CW-1:0]   absd1_ff, absd1_in;
   logic [AX-1:0]           dneg1_ff, dneg1_in;
   logic [SW-1:0]           rsum1_ff, rsum1_in;
   logic [AX-1:0][CW-1:0]   absa1_ff, absa1_in;
   logic [AX-1:0][CW-1:0]   absb1_ff, absb1_in;
   logic [AX-1:0][CW-1:0]   pa1_ff, pb1_ff;
   logic [IW-1:0]           ia1_ff, ib1_ff;

   // stage 2 registers
   logic                    v2_ff;
   logic                    reject2_ff;
   logic [AX-1:0][QW-1:0]   dsq2_ff, dsq2_in;
   logic [AX-1:0][QW-1:0]   prod2_ff, prod2_in;
   logic [QW-1:0]           ssq2_ff, ssq2_in;
   logic [AX-1:0][NW-1:0]   asq2_ff, asq2_in;
   logic [AX-1:0][NW-1:0]   bsq2_ff, bsq2_in;
   logic [AX-1:0]           dneg2_ff;
   logic [SW-1:0]           rsum2_ff;
   logic [AX-1:0][CW-1:0]   pa2_ff, pb2_ff;
   logic [IW-1:0]           ia2_ff, ib2_ff;

   // stage 3 registers
   logic                    v3_ff;
   logic                    reject3_ff;
   logic [NW-1:0]           dsum3_ff, dsum3_in;
   logic [NW-1:0]           na3_ff, na3_in;
   logic [NW-1:0]           nb3_ff, nb3_in;
   logic [QW-1:0]           ssq3_ff;
   logic [AX-1:0][QW-1:0]   prod3_ff;
   logic [AX-1:0]           dneg3_ff;
   logic [SW-1:0]           rsum3_ff;
   logic [AX-1:0][CW-1:0]   pa3_ff, pb3_ff;
   logic [IW-1:0]           ia3_ff, ib3_ff;

   // stage 4 registers
   logic                    v4_ff;
   ppor_pkg::ctx_type       ctx4_ff, ctx4_in;
   logic [QW-1:0]           rad4_ff;

   // separation, magnitudes, radius sum and early reject
   always_comb begin
      logic [CW:0] d;
      logic        far;
      far      = 1'b0;
      rsum1_in = {1'b0, in_rad_a} + {1'b0, in_rad_b};
      for (int k = 0; k < AX; k++) begin
         d            = {in_pos_a[k][CW-1], in_pos_a[k]} - {in_pos_b[k][CW-1], in_pos_b[k]};
         dneg1_in[k]  = d[CW];
         absd1_in[k]  = d[CW] ? CW'(~d + 1'b1) : d[CW-1:0];
         absa1_in[k]  = in_pos_a[k][CW-1] ? (~in_pos_a[k] + 1'b1) : in_pos_a[k];
         absb1_in[k]  = in_pos_b[k][CW-1] ? (~in_pos_b[k] + 1'b1) : in_pos_b[k];
         if (absd1_in[k] >= {1'b0, rsum1_in}) begin
            far = 1'b1;
         end
      end
      reject1_in = far || ({9'd0, in_index_a} >= MAX_P) || ({9'd0, in_index_b} >= MAX_P);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         reject1_ff <= reject1_in;
         absd1_ff   <= absd1_in;
         dneg1_ff   <= dneg1_in;
         rsum1_ff   <= rsum1_in;
         absa1_ff   <= absa1_in;
         absb1_ff   <= absb1_in;
         pa1_ff     <= in_pos_a;
         pb1_ff     <= in_pos_b;
         ia1_ff     <= in_index_a;
         ib1_ff     <= in_index_b;
      end
   end

   // squares and separation times radius sum
   always_comb begin
      for (int k = 0; k < AX; k++) begin
         dsq2_in[k]  = QW'(absd1_ff[k][SW-1:0] * absd1_ff[k][SW-1:0]);
         prod2_in[k] = QW'(absd1_ff[k][SW-1:0] * rsum1_ff);
         asq2_in[k]  = NW'(absa1_ff[k] * absa1_ff[k]);
         bsq2_in[k]  = NW'(absb1_ff[k] * absb1_ff[k]);
      end
      ssq2_in = QW'(rsum1_ff * rsum1_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         reject2_ff <= reject1_ff;
         dsq2_ff    <= dsq2_in;
         prod2_ff   <= prod2_in;
         ssq2_ff    <= ssq2_in;
         asq2_ff    <= asq2_in;
         bsq2_ff    <= bsq2_in;
         dneg2_ff   <= dneg1_ff;
         rsum2_ff   <= rsum1_ff;
         pa2_ff     <= pa1_ff;
         pb2_ff     <= pb1_ff;
         ia2_ff     <= ia1_ff;
         ib2_ff     <= ib1_ff;
      end
   end

   // sums of squares
   always_comb begin
      dsum3_in = NW'(dsq2_ff[0]) + NW'(dsq2_ff[1]) + NW'(dsq2_ff[2]);
      na3_in   = asq2_ff[0] + asq2_ff[1] + asq2_ff[2];
      nb3_in   = bsq2_ff[0] + bsq2_ff[1] + bsq2_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         reject3_ff <= reject2_ff;
         dsum3_ff   <= dsum3_in;
         na3_ff     <= na3_in;
         nb3_ff     <= nb3_in;
         ssq3_ff    <= ssq2_ff;
         prod3_ff   <= prod2_ff;
         dneg3_ff   <= dneg2_ff;
         rsum3_ff   <= rsum2_ff;
         pa3_ff     <= pa2_ff;
         pb3_ff     <= pb2_ff;
         ia3_ff     <= ia2_ff;
         ib3_ff     <= ib2_ff;
      end
   end

   // overlap decision and choice of the particle to move
   always_comb begin
      logic msec;
      msec                = !(na3_ff < nb3_ff);
      ctx4_in.overlap     = !reject3_ff && (dsum3_ff < NW'(ssq3_ff));
      ctx4_in.move_second = msec;
      ctx4_in.coincident  = (dsum3_ff == '0);
      ctx4_in.d_neg       = dneg3_ff;
      ctx4_in.moved_index = msec ? ib3_ff : ia3_ff;
      ctx4_in.base        = msec ? pa3_ff : pb3_ff;
      ctx4_in.rsum        = rsum3_ff;
      ctx4_in.prod        = prod3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ctx4_ff <= ctx4_in;
         rad4_ff <= dsum3_ff[QW-1:0];
      end
   end

   assign out_valid = v4_ff;
   assign out_ctx   = ctx4_ff;
   assign out_rad   = rad4_ff;

endmodule

FILE: rtl/ppor_sqrt.sv
// ppor_sqrt: pipelined integer square root, one root bit per stage
// depends on ppor_pkg
module ppor_sqrt (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              adv,
   input  logic                              in_valid,
   input  ppor_pkg::ctx_type                 in_ctx,
   input  logic [ppor_pkg::SQ_W-1:0]         in_rad,
   output logic                              out_valid,
   output ppor_pkg::ctx_type                 out_ctx,
   output logic [ppor_pkg::ROOT_W-1:0]       out_root
);

   localparam int N  = ppor_pkg::ROOT_STAGES;
   localparam int RW = ppor_pkg::ROOT_W;
   localparam int QW = ppor_pkg::SQ_W;
   localparam int MW = RW + 1;

   logic               v_ff    [N];
   ppor_pkg::ctx_type  ctx_ff  [N];
   logic [MW-1:0]      rem_ff  [N];
   logic [MW-1:0]      rem_in  [N];
   logic [RW-1:0]      root_ff [N];
   logic [RW-1:0]      root_in [N];
   logic [QW-1:0]      rad_ff  [N];
   logic               v_src   [N];
   ppor_pkg::ctx_type  ctx_src [N];
   logic [MW-1:0]      rem_src [N];
   logic [RW-1:0]      root_src[N];
   logic [QW-1:0]      rad_src [N];

   for (genvar i = 0; i < N; i++) begin : g_stage
      // stage source: module input or previous stage
      if (i == 0) begin : g_head
         assign v_src[i]    = in_valid;
         assign ctx_src[i]  = in_ctx;
         assign rem_src[i]  = '0;
         assign root_src[i] = '0;
         assign rad_src[i]  = in_rad;
      end else begin : g_body
         assign v_src[i]    = v_ff[i-1];
         assign ctx_src[i]  = ctx_ff[i-1];
         assign rem_src[i]  = rem_ff[i-1];
         assign root_src[i] = root_ff[i-1];
         assign rad_src[i]  = rad_ff[i-1];
      end

      // trial subtract of two radicand bits
      always_comb begin
         logic [MW+1:0] rem_sh;
         logic [MW+1:0] trial;
         rem_sh = {rem_src[i], rad_src[i][QW-1 -: 2]};
         trial  = {1'b0, root_src[i], 2'b01};
         if (rem_sh >= trial) begin
            rem_in[i]  = MW'(rem_sh - trial);
            root_in[i] = {root_src[i][RW-2:0], 1'b1};
         end else begin
            rem_in[i]  = MW'(rem_sh);
            root_in[i] = {root_src[i][RW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (adv) begin
            v_ff[i] <= v_src[i];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            ctx_ff[i]  <= ctx_src[i];
            rem_ff[i]  <= rem_in[i];
            root_ff[i] <= root_in[i];
            rad_ff[i]  <= {rad_src[i][QW-3:0], 2'b00};
         end
      end
   end

   assign out_valid = v_ff[N-1];
   assign out_ctx   = ctx_ff[N-1];
   assign out_root  = root_ff[N-1];

endmodule

FILE: rtl/ppor_div.sv
// ppor_div: rounding offset stage and pipelined restoring divide, three axes in parallel
// depends on ppor_pkg
module ppor_div (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            adv,
   input  logic                                            in_valid,
   input  ppor_pkg::ctx_type                               in_ctx,
   input  logic [ppor_pkg::ROOT_W-1:0]                     in_root,
   output logic                                            out_valid,
   output ppor_pkg::ctx_type                               out_ctx,
   output logic [ppor_pkg::AXES-1:0][ppor_pkg::QUO_W-1:0]  out_quo
);

   localparam int N  = ppor_pkg::DIV_STAGES;
   localparam int AX = ppor_pkg::AXES;
   localparam int RW = ppor_pkg::ROOT_W;
   localparam int QW = ppor_pkg::SQ_W;
   localparam int OW = ppor_pkg::QUO_W;
   localparam int LW = QW - OW;

   // numerator register: product plus half the root
   logic                    pv_ff;
   ppor_pkg::ctx_type       pctx_ff;
   logic [RW-1:0]           pr_ff;
   logic [AX-1:0][QW-1:0]   pnum_ff, pnum_in;

   always_comb begin
      for (int k = 0; k < AX; k++) begin
         pnum_in[k] = in_ctx.prod[k] + QW'(in_root >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else if (adv) begin
         pv_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pctx_ff <= in_ctx;
         pr_ff   <= in_root;
         pnum_ff <= pnum_in;
      end
   end

   logic                    v_ff    [N];
   ppor_pkg::ctx_type       ctx_ff  [N];
   logic [RW-1:0]           r_ff    [N];
   logic [AX-1:0][RW-1:0]   rem_ff  [N];
   logic [AX-1:0][RW-1:0]   rem_in  [N];
   logic [AX-1:0][LW-1:0]   num_ff  [N];
   logic [AX-1:0][LW-1:0]   num_in  [N];
   logic [AX-1:0][OW-1:0]   q_ff    [N];
   logic [AX-1:0][OW-1:0]   q_in    [N];
   logic                    v_src   [N];
   ppor_pkg::ctx_type       ctx_src [N];
   logic [RW-1:0]           r_src   [N];
   logic [AX-1:0][RW-1:0]   rem_src [N];
   logic [AX-1:0][LW-1:0]   num_src [N];
   logic [AX-1:0][OW-1:0]   q_src   [N];

   for (genvar i = 0; i < N; i++) begin : g_stage
      // stage source: numerator register or previous stage
      if (i == 0) begin : g_head
         assign v_src[i]   = pv_ff;
         assign ctx_src[i] = pctx_ff;
         assign r_src[i]   = pr_ff;
         assign q_src[i]   = '0;
         for (genvar k = 0; k < AX; k++) begin : g_axis
            assign rem_src[i][k] = pnum_ff[k][QW-1 -: RW];
            assign num_src[i][k] = pnum_ff[k][LW-1:0];
         end
      end else begin : g_body
         assign v_src[i]   = v_ff[i-1];
         assign ctx_src[i] = ctx_ff[i-1];
         assign r_src[i]   = r_ff[i-1];
         assign rem_src[i] = rem_ff[i-1];
         assign num_src[i] = num_ff[i-1];
         assign q_src[i]   = q_ff[i-1];
      end

      // one quotient bit per axis
      always_comb begin
         logic [RW:0] rem_sh;
         for (int k = 0; k < AX; k++) begin
            rem_sh       = {rem_src[i][k], num_src[i][k][LW-1]};
            num_in[i][k] = {num_src[i][k][LW-2:0], 1'b0};
            if (rem_sh >= {1'b0, r_src[i]}) begin
               rem_in[i][k] = RW'(rem_sh - {1'b0, r_src[i]});
               q_in[i][k]   = {q_src[i][k][OW-2:0], 1'b1};
            end else begin
               rem_in[i][k] = rem_sh[RW-1:0];
               q_in[i][k]   = {q_src[i][k][OW-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (adv) begin
            v_ff[i] <= v_src[i];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            ctx_ff[i] <= ctx_src[i];
            r_ff[i]   <= r_src[i];
            rem_ff[i] <= rem_in[i];
            num_ff[i] <= num_in[i];
            q_ff[i]   <= q_in[i];
         end
      end
   end

   assign out_valid = v_ff[N-1];
   assign out_ctx   = ctx_ff[N-1];
   assign out_quo   = q_ff[N-1];

endmodule

FILE: rtl/particle_pair_overlap_resolver.sv
// particle_pair_overlap_resolver: pipeline stages from request to response register
// (4 front stages, 31 root stages, 1 offset and 31 divide stages, 1 output stage)
// throughput one pair per cycle, set by the fully pipelined root and divide units
// a skid entry takes the transaction that leaves the divider while a response waits;
// requests stall only while that entry is full
// synchronous active-high reset clears all valid bits; payload registers are not reset
module particle_pair_overlap_resolver #(
   parameter int unsigned MAX_PARTICLES = 65536
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [15:0]         req_first_index,
   input  logic [15:0]         req_second_index,
   input  logic signed [31:0]  req_first_x,
   input  logic signed [31:0]  req_first_y,
   input  logic signed [31:0]  req_first_z,
   input  logic [29:0]         req_first_radius,
   input  logic signed [31:0]  req_second_x,
   input  logic signed [31:0]  req_second_y,
   input  logic signed [31:0]  req_second_z,
   input  logic [29:0]         req_second_radius,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_overlapped,
   output logic                rsp_moved_is_second,
   output logic [15:0]         rsp_moved_index,
   output logic signed [31:0]  rsp_new_x,
   output logic signed [31:0]  rsp_new_y,
   output logic signed [31:0]  rsp_new_z
);

   localparam int AX = ppor_pkg::AXES;
   localparam int CW = ppor_pkg::COORD_W;
   localparam int OW = ppor_pkg::QUO_W;
   localparam int IW = ppor_pkg::IDX_W;
   localparam int XW = CW + 2;

   typedef struct packed {
      logic                  overlapped;
      logic                  moved_is_second;
      logic [IW-1:0]         moved_index;
      logic [AX-1:0][CW-1:0] pos;
   } rsp_type;

   logic                                adv;
   logic [AX-1:0][CW-1:0]               pos_a, pos_b;
   logic                                fr_valid, sq_valid, dv_valid;
   ppor_pkg::ctx_type                   fr_ctx, sq_ctx, dv_ctx;
   logic [ppor_pkg::SQ_W-1:0]           fr_rad;
   logic [ppor_pkg::ROOT_W-1:0]         sq_root;
   logic [AX-1:0][OW-1:0]               dv_quo;
   rsp_type                             res;
   logic                                rsp_valid_ff, skid_valid_ff;
   rsp_type                             rsp_ff, skid_ff;

   // whole pipeline moves unless the response buffer is full
   assign adv       = !skid_valid_ff;
   assign req_ready = adv;

   assign pos_a = {req_first_z, req_first_y, req_first_x};
   assign pos_b = {req_second_z, req_second_y, req_second_x};

   ppor_front #(
      .MAX_PARTICLES(MAX_PARTICLES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .in_valid   (req_valid),
      .in_index_a (req_first_index),
      .in_index_b (req_second_index),
      .in_pos_a   (pos_a),
      .in_pos_b   (pos_b),
      .in_rad_a   (req_first_radius),
      .in_rad_b   (req_second_radius),
      .out_valid  (fr_valid),
      .out_ctx    (fr_ctx),
      .out_rad    (fr_rad)
   );

   ppor_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (fr_valid),
      .in_ctx    (fr_ctx),
      .in_rad    (fr_rad),
      .out_valid (sq_valid),
      .out_ctx   (sq_ctx),
      .out_root  (sq_root)
   );

   ppor_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (sq_valid),
      .in_ctx    (sq_ctx),
      .in_root   (sq_root),
      .out_valid (dv_valid),
      .out_ctx   (dv_ctx),
      .out_quo   (dv_quo)
   );

   // apply signed offset to the fixed centre and saturate; zero payload when no overlap
   always_comb begin
      logic [OW-1:0]        mag;
      logic                 negate;
      logic signed [XW-1:0] sum;
      res.overlapped      = dv_ctx.overlap;
      res.moved_is_second = dv_ctx.overlap && dv_ctx.move_second;
      res.moved_index     = dv_ctx.overlap ? dv_ctx.moved_index : '0;
      for (int k = 0; k < AX; k++) begin
         if (dv_ctx.coincident) begin
            mag    = (k == 0) ? dv_ctx.rsum : '0;
            negate = dv_ctx.move_second;
         end else begin
            mag    = dv_quo[k];
            negate = dv_ctx.move_second ^ dv_ctx.d_neg[k];
         end
         if (negate) begin
            sum = XW'($signed(dv_ctx.base[k])) - $signed({3'b000, mag});
         end else begin
            sum = XW'($signed(dv_ctx.base[k])) + $signed({3'b000, mag});
         end
         if (!dv_ctx.overlap) begin
            res.pos[k] = '0;
         end else if (sum > $signed({{(XW-CW+1){1'b0}}, {(CW-1){1'b1}}})) begin
            res.pos[k] = {1'b0, {(CW-1){1'b1}}};
         end else if (sum < $signed({{(XW-CW+1){1'b1}}, {(CW-1){1'b0}}})) begin
            res.pos[k] = {1'b1, {(CW-1){1'b0}}};
         end else begin
            res.pos[k] = sum[CW-1:0];
         end
      end
   end

   // response register with skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_ready) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (dv_valid) begin
         if (!rsp_valid_ff || rsp_ready) begin
            rsp_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_ready) begin
            rsp_ff <= skid_ff;
         end
      end else if (dv_valid) begin
         if (!rsp_valid_ff || rsp_ready) begin
            rsp_ff <= res;
         end else begin
            skid_ff <= res;
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_overlapped      = rsp_ff.overlapped;
   assign rsp_moved_is_second = rsp_ff.moved_is_second;
   assign rsp_moved_index     = rsp_ff.moved_index;
   assign rsp_new_x           = rsp_ff.pos[0];
   assign rsp_new_y           = rsp_ff.pos[1];
   assign rsp_new_z           = rsp_ff.pos[2];

`ifndef SYNTH
   // skid entry only ever holds a transaction behind a waiting response
   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry valid without response valid");

   // skid fills only when the response was stalled
   a_skid_fill_on_stall: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !$past(skid_valid_ff)) |-> !$past(rsp_ready))
      else $error("skid filled while response was taken");

   // non-overlap responses carry all-zero payload
   a_no_overlap_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_overlapped) |-> (!rsp_moved_is_second && rsp_moved_index == '0
         && rsp_new_x == '0 && rsp_new_y == '0 && rsp_new_z == '0))
      else $error("non-overlap response with nonzero payload");
`endif

endmodule
